>>> rtl/i2c_rsq_pkg.sv
// ----------------------------------------------------------------------------
// i2c_rsq_pkg: shared types and constants of the i2c register sequencer
// item layouts, bus command and error codes, status event codes
// ----------------------------------------------------------------------------
package i2c_rsq_pkg;

  localparam int BUFFER_DEPTH = 32;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_EVENT  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_CONT  = 3'd3,
    CMD_ACK   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ERR_PENDING   = 3'd0,
    ERR_OK        = 3'd1,
    ERR_BUS       = 3'd2,
    ERR_ADDR_NACK = 3'd3,
    ERR_NACK      = 3'd4,
    ERR_UNKNOWN   = 3'd5
  } err_t;

  // bus status codes (status register divided by eight)
  localparam logic [4:0] ST_BUS_FAIL     = 5'd0;
  localparam logic [4:0] ST_START        = 5'd1;
  localparam logic [4:0] ST_RESTART      = 5'd2;
  localparam logic [4:0] ST_SLA_W_ACK    = 5'd3;
  localparam logic [4:0] ST_SLA_W_NACK   = 5'd4;
  localparam logic [4:0] ST_DATA_ACK     = 5'd5;
  localparam logic [4:0] ST_DATA_NACK    = 5'd6;
  localparam logic [4:0] ST_ARB_LOST     = 5'd7;
  localparam logic [4:0] ST_SLA_R_ACK    = 5'd8;
  localparam logic [4:0] ST_SLA_R_NACK   = 5'd9;
  localparam logic [4:0] ST_RX_ACKED     = 5'd10;
  localparam logic [4:0] ST_RX_NACKED    = 5'd11;

  // input tdata layout, first member is the top bits
  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] bus_rx_byte;
    logic [4:0] status_code;
    logic [7:0] buf_byte;
    logic [4:0] buf_index;
    logic       is_read;
    logic [5:0] byte_count;
    logic [7:0] reg_addr;
  } in_data_t;

  // result tdata layout, first member is the top bits
  typedef struct packed {
    logic [6:0] pad;
    logic [2:0] error_code;
    logic       done_res;
    logic [7:0] rx_index;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [2:0] bus_command;
  } res_t;

  // write request to the data buffer
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } wr_req_t;

endpackage

>>> rtl/i2c_rsq_wbuf.sv
// ----------------------------------------------------------------------------
// i2c_rsq_wbuf: write data buffer
// one write port, one registered read port with write-through on collision
// ----------------------------------------------------------------------------
module i2c_rsq_wbuf #(
  parameter int BUFFER_DEPTH = i2c_rsq_pkg::BUFFER_DEPTH
) (
  input  logic                 clk,
  input  i2c_rsq_pkg::wr_req_t wr,
  input  logic [7:0]           rd_addr,
  output logic [7:0]           rd_data
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [7:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_data <= wr.data;
    end else begin
      rd_data <= mem[rd_addr[AW-1:0]];
    end
  end

endmodule

>>> rtl/i2c_rsq_core.sv
// ----------------------------------------------------------------------------
// i2c_rsq_core: transaction state and per-item decision logic
// holds the transaction registers and computes one result per item
// ----------------------------------------------------------------------------
module i2c_rsq_core #(
  parameter int BUFFER_DEPTH = i2c_rsq_pkg::BUFFER_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  i2c_rsq_pkg::mode_t    mode,
  input  i2c_rsq_pkg::in_data_t item,
  input  logic [6:0]            target_address,
  input  logic [7:0]            rd_data,
  output logic [7:0]            rd_addr,
  output i2c_rsq_pkg::wr_req_t  wr,
  output i2c_rsq_pkg::res_t     res
);

  localparam logic [7:0] DEPTH8 = 8'(BUFFER_DEPTH);

  logic [7:0]        reg_address;
  logic [5:0]        transfer_count;
  logic [7:0]        byte_position;
  logic              read_direction;
  logic              busy;
  i2c_rsq_pkg::err_t last_error;

  logic [7:0]        reg_address_next;
  logic [5:0]        transfer_count_next;
  logic [7:0]        byte_position_next;
  logic              read_direction_next;
  logic              busy_next;
  i2c_rsq_pkg::err_t last_error_next;

  logic [7:0]        pos_inc;

  assign pos_inc = byte_position + 8'd1;

  // read the slot the next item will see
  assign rd_addr = fire ? byte_position_next : byte_position;

  always_comb begin
    reg_address_next    = reg_address;
    transfer_count_next = transfer_count;
    byte_position_next  = byte_position;
    read_direction_next = read_direction;
    busy_next           = busy;
    last_error_next     = last_error;
    wr                  = '0;
    res                 = '0;

    unique case (mode)
      i2c_rsq_pkg::MODE_START: begin
        if (!busy) begin
          if ({2'b00, item.byte_count} > DEPTH8) begin
            transfer_count_next = 6'(BUFFER_DEPTH);
          end else begin
            transfer_count_next = item.byte_count;
          end
          reg_address_next    = item.reg_addr;
          read_direction_next = item.is_read;
          byte_position_next  = '0;
          busy_next           = 1'b1;
          last_error_next     = i2c_rsq_pkg::ERR_PENDING;
          res.bus_command     = i2c_rsq_pkg::CMD_START;
        end
      end
      i2c_rsq_pkg::MODE_LOAD: begin
        // slots beyond the buffer are dropped
        wr.en   = ({3'b000, item.buf_index} < DEPTH8);
        wr.addr = {3'b000, item.buf_index};
        wr.data = item.buf_byte;
      end
      i2c_rsq_pkg::MODE_EVENT: begin
        if (busy) begin
          case (item.status_code)
            i2c_rsq_pkg::ST_BUS_FAIL: begin
              last_error_next = i2c_rsq_pkg::ERR_BUS;
            end
            i2c_rsq_pkg::ST_START: begin
              res.tx_valid    = 1'b1;
              res.tx_byte     = {target_address, 1'b0};
              res.bus_command = i2c_rsq_pkg::CMD_CONT;
            end
            i2c_rsq_pkg::ST_RESTART: begin
              res.tx_valid    = 1'b1;
              res.tx_byte     = {target_address, 1'b1};
              res.bus_command = i2c_rsq_pkg::CMD_CONT;
            end
            i2c_rsq_pkg::ST_SLA_W_ACK: begin
              res.tx_valid    = 1'b1;
              res.tx_byte     = reg_address;
              res.bus_command = i2c_rsq_pkg::CMD_CONT;
            end
            i2c_rsq_pkg::ST_SLA_W_NACK: begin
              res.bus_command = i2c_rsq_pkg::CMD_STOP;
              res.done_res    = 1'b1;
              busy_next       = 1'b0;
              last_error_next = i2c_rsq_pkg::ERR_ADDR_NACK;
            end
            i2c_rsq_pkg::ST_DATA_ACK: begin
              if (read_direction) begin
                // register address sent, turn around with repeated start
                res.bus_command = i2c_rsq_pkg::CMD_START;
              end else if (byte_position < {2'b00, transfer_count}) begin
                res.tx_valid       = 1'b1;
                res.tx_byte        = (byte_position < DEPTH8) ? rd_data : 8'd0;
                byte_position_next = pos_inc;
                res.bus_command    = i2c_rsq_pkg::CMD_CONT;
              end else begin
                res.bus_command = i2c_rsq_pkg::CMD_STOP;
                res.done_res    = 1'b1;
                busy_next       = 1'b0;
                last_error_next = i2c_rsq_pkg::ERR_OK;
              end
            end
            i2c_rsq_pkg::ST_DATA_NACK, i2c_rsq_pkg::ST_SLA_R_NACK: begin
              res.bus_command = i2c_rsq_pkg::CMD_STOP;
              res.done_res    = 1'b1;
              busy_next       = 1'b0;
              last_error_next = i2c_rsq_pkg::ERR_NACK;
            end
            i2c_rsq_pkg::ST_ARB_LOST: begin
              res.bus_command = i2c_rsq_pkg::CMD_STOP;
              res.done_res    = 1'b1;
              busy_next       = 1'b0;
              last_error_next = i2c_rsq_pkg::ERR_UNKNOWN;
            end
            i2c_rsq_pkg::ST_SLA_R_ACK: begin
              res.bus_command = (transfer_count > 6'd1) ? i2c_rsq_pkg::CMD_ACK
                                                        : i2c_rsq_pkg::CMD_CONT;
            end
            i2c_rsq_pkg::ST_RX_ACKED: begin
              res.rx_valid       = 1'b1;
              res.rx_byte        = item.bus_rx_byte;
              res.rx_index       = byte_position;
              byte_position_next = pos_inc;
              // ack while at least two more bytes are due
              res.bus_command = (({1'b0, pos_inc} + 9'd1) < {3'b000, transfer_count})
                                ? i2c_rsq_pkg::CMD_ACK : i2c_rsq_pkg::CMD_CONT;
            end
            i2c_rsq_pkg::ST_RX_NACKED: begin
              res.rx_valid       = 1'b1;
              res.rx_byte        = item.bus_rx_byte;
              res.rx_index       = byte_position;
              byte_position_next = pos_inc;
              res.bus_command    = i2c_rsq_pkg::CMD_STOP;
              res.done_res       = 1'b1;
              busy_next          = 1'b0;
              last_error_next    = i2c_rsq_pkg::ERR_OK;
            end
            default: begin
              res.done_res    = 1'b1;
              busy_next       = 1'b0;
              last_error_next = i2c_rsq_pkg::ERR_UNKNOWN;
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    res.error_code = last_error_next;
    if (!fire) begin
      wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_address    <= '0;
      transfer_count <= '0;
      byte_position  <= '0;
      read_direction <= 1'b0;
      busy           <= 1'b0;
      last_error     <= i2c_rsq_pkg::ERR_PENDING;
    end else if (fire) begin
      reg_address    <= reg_address_next;
      transfer_count <= transfer_count_next;
      byte_position  <= byte_position_next;
      read_direction <= read_direction_next;
      busy           <= busy_next;
      last_error     <= last_error_next;
    end
  end

endmodule

>>> rtl/i2c_master_register_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_register_sequencer_unit: i2c master register read/write sequencer
// answers each start, buffer load or bus status item with one bus command item
// ----------------------------------------------------------------------------
// usage
//   s_axis carries the items: tuser is the item kind (start transaction,
//   load write buffer, bus status event), tdata the payload fields
//   m_axis carries one result per item: bus command, byte to send, received
//   byte with its index, done flag and current error code
//   cfg writes the seven-bit target address; write it only while no item is
//   in flight, cfg_ready is always high
// timing
//   an item is registered at the input, decided in one pass against the
//   transaction state and the write buffer, and registered at the output:
//   m_axis_tvalid rises one cycle after the s_axis accept edge, one item per
//   cycle sustained, set by the single decision pass and the buffer read port
// reset
//   rst is synchronous: the sequencer goes idle with error code pending, the
//   target address returns to zero; buffer contents are kept (undefined
//   until loaded)
// backpressure
//   while m_axis is stalled the held result stays put and one more item is
//   taken into the input register, then s_axis_tready drops
// ----------------------------------------------------------------------------
module i2c_master_register_sequencer_unit #(
  parameter int BUFFER_DEPTH = i2c_rsq_pkg::BUFFER_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // reg_addr[7:0], byte_count[13:8], is_read[14], buf_index[19:15],
  // buf_byte[27:20], status_code[32:28], bus_rx_byte[40:33], zero[47:41]
  input  logic [i2c_rsq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]                         s_axis_tuser,
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // bus_command[2:0], tx_valid[3], tx_byte[11:4], rx_valid[12],
  // rx_byte[20:13], rx_index[28:21], done_res[29], error_code[32:30],
  // zero[39:33]
  output logic [i2c_rsq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // target address writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [6:0]                         cfg_data
);

  logic                  in_valid;
  i2c_rsq_pkg::in_data_t in_item;
  i2c_rsq_pkg::mode_t    in_mode;
  logic                  fire;

  logic [6:0]            target_address;

  logic [7:0]            rd_addr;
  logic [7:0]            rd_data;
  i2c_rsq_pkg::wr_req_t  wr;
  i2c_rsq_pkg::res_t     res;

  logic                  out_valid;
  i2c_rsq_pkg::res_t     out_res;

  // the input register moves on when the output slot is free or being drained
  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign cfg_ready     = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= i2c_rsq_pkg::in_data_t'(s_axis_tdata);
      in_mode <= i2c_rsq_pkg::mode_t'(s_axis_tuser);
    end
  end

  // target address register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= '0;
    end else if (cfg_valid) begin
      target_address <= cfg_data;
    end
  end

  i2c_rsq_wbuf #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_wbuf (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  i2c_rsq_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .mode           (in_mode),
    .item           (in_item),
    .target_address (target_address),
    .rd_data        (rd_data),
    .rd_addr        (rd_addr),
    .wr             (wr),
    .res            (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res;

endmodule

>>> tb/sv/i2c_master_register_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_register_sequencer_unit_tb: self-checking bench for the sequencer
// drives start, buffer load and bus status items with random gaps, predicts
// each result item from its own copy of the sequencer state, checks every
// result field, and stalls the result side at random and twice for long stretches
// ----------------------------------------------------------------------------
module i2c_master_register_sequencer_unit_tb;
  import i2c_rsq_pkg::*;

  localparam int CYCLE_LIMIT = 300000;  // far beyond the slowest correct run
  localparam int LONG_HOLD   = 300;     // long result-side hold-off, in cycles
  localparam int PHASE_ITEMS = 210;     // random items between target changes
  localparam int NUM_PHASES  = 5;

  // --------------------------------------------------------------------------
  // scoreboard: shadow of the sequencer state plus the results still due
  // --------------------------------------------------------------------------
  class sequencer_scoreboard;
    logic [6:0] target;
    logic [7:0] reg_addr;
    logic [5:0] xfer_count;
    logic [7:0] byte_pos;
    logic       read_dir;
    logic       busy;
    err_t       last_err;
    logic [7:0] wbuf [BUFFER_DEPTH];
    bit         loaded [BUFFER_DEPTH];
    res_t       due_answers [$];
    int         errors;

    function new();
      target     = '0;
      reg_addr   = '0;
      xfer_count = '0;
      byte_pos   = '0;
      read_dir   = 1'b0;
      busy       = 1'b0;
      last_err   = ERR_PENDING;
      errors     = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    function void close_txn(input err_t e, input cmd_t c, output cmd_t cmd_o,
                            output logic done_o);
      last_err = e;
      busy     = 1'b0;
      cmd_o    = c;
      done_o   = 1'b1;
    endfunction

    // works out the result of one accepted item and queues it
    function void note_item(mode_t m, in_data_t d);
      res_t ans;
      cmd_t cmd;
      logic done;
      int   cnt;
      ans  = '0;
      cmd  = CMD_NONE;
      done = 1'b0;
      case (m)
        MODE_START: begin
          // a start while a transaction runs is ignored
          if (!busy) begin
            cnt = int'(d.byte_count);
            if (cnt > BUFFER_DEPTH) cnt = BUFFER_DEPTH;
            reg_addr   = d.reg_addr;
            xfer_count = 6'(cnt);
            read_dir   = d.is_read;
            byte_pos   = '0;
            busy       = 1'b1;
            last_err   = ERR_PENDING;
            cmd        = CMD_START;
          end
        end
        MODE_LOAD: begin
          wbuf[d.buf_index]   = d.buf_byte;
          loaded[d.buf_index] = 1'b1;
        end
        MODE_EVENT: begin
          // status events while idle are dropped
          if (busy) begin
            case (d.status_code)
              ST_BUS_FAIL: last_err = ERR_BUS;  // busy stays set, no command
              ST_START: begin
                ans.tx_valid = 1'b1;
                ans.tx_byte  = {target, 1'b0};
                cmd          = CMD_CONT;
              end
              ST_RESTART: begin
                ans.tx_valid = 1'b1;
                ans.tx_byte  = {target, 1'b1};
                cmd          = CMD_CONT;
              end
              ST_SLA_W_ACK: begin
                ans.tx_valid = 1'b1;
                ans.tx_byte  = reg_addr;
                cmd          = CMD_CONT;
              end
              ST_SLA_W_NACK: close_txn(ERR_ADDR_NACK, CMD_STOP, cmd, done);
              ST_DATA_ACK: begin
                if (read_dir) begin
                  cmd = CMD_START;  // register address sent, go for repeated start
                end else if (byte_pos < {2'b00, xfer_count}) begin
                  ans.tx_valid = 1'b1;
                  ans.tx_byte  = (byte_pos < BUFFER_DEPTH) ? wbuf[byte_pos[4:0]] : 8'h00;
                  byte_pos     = byte_pos + 8'd1;
                  cmd          = CMD_CONT;
                end else begin
                  close_txn(ERR_OK, CMD_STOP, cmd, done);
                end
              end
              ST_DATA_NACK, ST_SLA_R_NACK: close_txn(ERR_NACK, CMD_STOP, cmd, done);
              ST_ARB_LOST: close_txn(ERR_UNKNOWN, CMD_STOP, cmd, done);
              ST_SLA_R_ACK: cmd = (xfer_count > 6'd1) ? CMD_ACK : CMD_CONT;
              ST_RX_ACKED: begin
                ans.rx_valid = 1'b1;
                ans.rx_byte  = d.bus_rx_byte;
                ans.rx_index = byte_pos;
                byte_pos     = byte_pos + 8'd1;
                // ack while more than one byte is still to come
                cmd = (int'(byte_pos) + 1 < int'(xfer_count)) ? CMD_ACK : CMD_CONT;
              end
              ST_RX_NACKED: begin
                ans.rx_valid = 1'b1;
                ans.rx_byte  = d.bus_rx_byte;
                ans.rx_index = byte_pos;
                byte_pos     = byte_pos + 8'd1;
                close_txn(ERR_OK, CMD_STOP, cmd, done);
              end
              default: close_txn(ERR_UNKNOWN, CMD_NONE, cmd, done);  // unknown status
            endcase
          end
        end
        default: ;  // unused mode gives an empty result
      endcase
      ans.bus_command = cmd;
      ans.done_res    = done;
      ans.error_code  = last_err;
      due_answers.push_back(ans);
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got_v);
      $display("%0t mismatch %s: expected %0h, got %0h", $time, field, want, got_v);
      errors++;
    endfunction

    // compares one accepted result with the oldest one due
    function void check_answer(res_t got);
      res_t want;
      if (due_answers.size() == 0) begin
        $display("%0t unexpected result: expected none, got %0h", $time, got);
        errors++;
        return;
      end
      want = due_answers.pop_front();
      if (got.bus_command !== want.bus_command)
        report("bus_command", 8'(want.bus_command), 8'(got.bus_command));
      if (got.tx_valid !== want.tx_valid)
        report("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      if (got.tx_byte !== want.tx_byte) report("tx_byte", want.tx_byte, got.tx_byte);
      if (got.rx_valid !== want.rx_valid)
        report("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
      if (got.rx_byte !== want.rx_byte) report("rx_byte", want.rx_byte, got.rx_byte);
      if (got.rx_index !== want.rx_index) report("rx_index", want.rx_index, got.rx_index);
      if (got.done_res !== want.done_res)
        report("done_res", 8'(want.done_res), 8'(got.done_res));
      if (got.error_code !== want.error_code)
        report("error_code", 8'(want.error_code), 8'(got.error_code));
      if (got.pad !== want.pad) report("zero bits", 8'(want.pad), 8'(got.pad));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [6:0]            cfg_data      = '0;

  sequencer_scoreboard sb;

  int          counted      = 0;     // items that the block acts on
  int          raw_items    = 0;     // every item offered, for idling stretches
  bit          tx_quiet     = 1'b0;  // sender offers back to back
  bit          rx_quiet     = 1'b0;  // receiver takes back to back
  bit          hold_req     = 1'b0;  // asks the receiver for one long hold-off
  int unsigned cycle_count  = 0;
  logic        ans_seen     = 1'b0;
  res_t        ans_word;
  logic [4:0]  step_q [$];           // status events of the transaction in play

  always #6 clk = ~clk;

  i2c_master_register_sequencer_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // run limit: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result capture at the rising edge, check at the falling edge so that items noted
  // at the same edge are always in the scoreboard first
  always @(posedge clk) begin
    ans_seen <= !rst && m_axis_tvalid && m_axis_tready;
    ans_word <= m_axis_tdata;
  end

  always @(negedge clk) begin
    if (ans_seen) sb.check_answer(ans_word);
  end

  // --------------------------------------------------------------------------
  // result side: random stalls per item, quiet stretches, one long hold-off
  // on request so that the block fills up and drops s_axis_tready
  // --------------------------------------------------------------------------
  initial begin : result_side
    int stall;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      taken++;
      stall = rx_quiet ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // --------------------------------------------------------------------------
  // item driving: called at a rising edge, returns at the edge of acceptance
  // --------------------------------------------------------------------------
  function automatic in_data_t rand_word();
    in_data_t d;
    d             = '0;
    d.reg_addr    = 8'($urandom_range(0, 255));
    d.byte_count  = 6'($urandom_range(0, 63));
    d.is_read     = 1'($urandom_range(0, 1));
    d.buf_index   = 5'($urandom_range(0, 31));
    d.buf_byte    = 8'($urandom_range(0, 255));
    d.status_code = 5'($urandom_range(0, 31));
    d.bus_rx_byte = 8'($urandom_range(0, 255));
    return d;
  endfunction

  task automatic send_item(input mode_t m, input in_data_t d);
    int gap;
    if (raw_items % 40 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
    raw_items++;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    if (!(m == MODE_UNUSED || (m == MODE_EVENT && !sb.busy) || (m == MODE_START && sb.busy)))
      counted++;
    sb.note_item(m, d);
  endtask

  task automatic send_load(input logic [4:0] idx, input logic [7:0] val);
    in_data_t d;
    d           = rand_word();
    d.buf_index = idx;
    d.buf_byte  = val;
    send_item(MODE_LOAD, d);
  endtask

  task automatic send_start(input logic [7:0] ra, input logic [5:0] cnt, input logic rd);
    in_data_t d;
    d            = rand_word();
    d.reg_addr   = ra;
    d.byte_count = cnt;
    d.is_read    = rd;
    send_item(MODE_START, d);
  endtask

  task automatic send_event(input logic [4:0] st);
    in_data_t d;
    // a data ack in a write must never reach a slot that was never loaded
    if (st == ST_DATA_ACK && sb.busy && !sb.read_dir && sb.byte_pos < {2'b00, sb.xfer_count} &&
        !sb.loaded[sb.byte_pos[4:0]])
      send_load(sb.byte_pos[4:0], 8'($urandom_range(0, 255)));
    d             = rand_word();
    d.status_code = st;
    send_item(MODE_EVENT, d);
  endtask

  // target address write, only while no result is due
  task automatic write_target(input logic [6:0] addr);
    s_axis_tvalid <= 1'b0;
    while (sb.due_answers.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    sb.target = addr;
    cfg_valid <= 1'b0;
  endtask

  // mostly short runs, some long ones, a few at and above the buffer depth
  function automatic logic [5:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 6'($urandom_range(0, 6));
    if (r < 8) return 6'($urandom_range(7, 31));
    if (r == 8) return 6'd32;
    return 6'($urandom_range(33, 63));
  endfunction

  // plays the queued bus events, sometimes breaking off with a random status
  task automatic play_steps();
    int abort_at;
    abort_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, step_q.size() - 1) : -1;
    foreach (step_q[k]) begin
      if (k == abort_at) begin
        send_event(5'($urandom_range(0, 31)));
        if (sb.busy) send_event(ST_ARB_LOST);
        return;
      end
      send_event(step_q[k]);
    end
  endtask

  // one well-formed register transaction with random content
  task automatic run_txn(input logic rd);
    logic [5:0] n;
    int         lim;
    n   = pick_count();
    lim = (n > BUFFER_DEPTH) ? BUFFER_DEPTH : n;
    // mostly clear a leftover transaction, sometimes start into it
    if (sb.busy && $urandom_range(0, 3) != 0) send_event(ST_ARB_LOST);
    if (!rd) begin
      for (int i = 0; i < lim; i++) send_load(5'(i), 8'($urandom_range(0, 255)));
    end
    send_start(8'($urandom_range(0, 255)), n, rd);
    step_q.delete();
    step_q.push_back(ST_START);
    step_q.push_back(ST_SLA_W_ACK);
    if (rd) begin
      step_q.push_back(ST_DATA_ACK);
      step_q.push_back(ST_RESTART);
      step_q.push_back(ST_SLA_R_ACK);
      for (int i = 1; i < lim; i++) step_q.push_back(ST_RX_ACKED);
      step_q.push_back(ST_RX_NACKED);
    end else begin
      for (int i = 0; i <= lim; i++) step_q.push_back(ST_DATA_ACK);
    end
    play_steps();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          pick;
    int          phase_end;
    logic [6:0]  phase_target;
    mode_t       noise_mode;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part, top target address so the address bytes are 8'hfe / 8'hff
    write_target(7'h7F);
    send_event(ST_START);                 // status while idle is dropped
    send_load(5'd0, 8'h00);
    send_load(5'd1, 8'hFF);
    send_load(5'd2, 8'h5A);
    send_load(5'd31, 8'hFF);
    send_start(8'hFF, 6'd3, 1'b0);        // three-byte register write
    send_start(8'h00, 6'd63, 1'b1);       // start while busy is ignored
    send_event(ST_START);
    send_event(ST_SLA_W_ACK);
    repeat (4) send_event(ST_DATA_ACK);   // three data bytes, then stop
    send_item(MODE_UNUSED, rand_word());
    send_start(8'h00, 6'd63, 1'b1);       // read, count saturates at the depth
    send_event(ST_START);
    send_event(ST_SLA_W_ACK);
    send_event(ST_DATA_ACK);              // repeated start
    send_event(ST_RESTART);
    send_event(ST_SLA_R_ACK);
    send_event(ST_RX_ACKED);
    send_event(ST_RX_NACKED);
    send_start(8'h80, 6'd0, 1'b0);
    send_event(ST_BUS_FAIL);              // error set, still busy
    send_event(5'd31);                    // unknown status clears busy

    // random phases, each under its own target address
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       phase_target = 7'h00;
        2:       phase_target = 7'h7F;
        default: phase_target = 7'($urandom_range(0, 127));
      endcase
      write_target(phase_target);
      if (phase == 1 || phase == 3) hold_req = 1'b1;
      phase_end = counted + PHASE_ITEMS;
      while (counted < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          run_txn(1'b0);
        end else if (pick < 17) begin
          run_txn(1'b1);
        end else begin
          // noise: loose items of any kind
          repeat ($urandom_range(1, 4)) begin
            noise_mode = mode_t'($urandom_range(0, 3));
            if (noise_mode == MODE_EVENT) send_event(5'($urandom_range(0, 31)));
            else send_item(noise_mode, rand_word());
          end
        end
      end
    end

    // drain, then wait out anything stray
    s_axis_tvalid <= 1'b0;
    while (sb.due_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
